FILE: design/hps_pkg.sv
// ----------------------------------------------------------------------------
// Haptic pattern sequencer package
// Shared widths, opcodes, pattern codes, the step ROM and the pattern tables.
// ----------------------------------------------------------------------------
package hps_pkg;

	localparam int HPS_TIME_BITS = 32;
	localparam int HPS_PAT_W     = 3;
	localparam int HPS_POS_W     = 5;
	localparam int HPS_LVL_W     = 7;
	localparam int HPS_IN_LVL_W  = 8;
	localparam int HPS_PROD_W    = 14;
	localparam int HPS_DUR_W     = 10;
	localparam int HPS_IDX_W     = 6;
	localparam int HPS_MAX_LEVEL = 100;
	localparam int HPS_MAX_LEN   = 17;

	// Division by 100 as a multiply by a reciprocal; exact for products below 43690.
	localparam int HPS_DIV_MUL_W = 13;
	localparam logic [HPS_DIV_MUL_W-1:0] HPS_DIV100_MUL = 13'd5243;
	localparam int HPS_DIV100_SHIFT = 19;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_PLAY  = 2'd1,
		OP_LEVEL = 2'd2,
		OP_STOP  = 2'd3
	} hps_op_t;

	localparam logic [HPS_PAT_W-1:0] PAT_NONE      = 3'd0;
	localparam logic [HPS_PAT_W-1:0] PAT_BREATHING = 3'd5;
	localparam logic [HPS_PAT_W-1:0] PAT_INVALID   = 3'd7;

	typedef struct packed {
		hps_op_t                 op;
		logic [HPS_PAT_W-1:0]    sel;
		logic [HPS_IN_LVL_W-1:0] level;
	} hps_cmd_t;

	typedef struct packed {
		logic [HPS_PROD_W-1:0] prod;
		logic                  driver_on;
		logic                  running;
	} hps_status_t;

	typedef struct packed {
		logic [HPS_DUR_W-1:0] dur;
		logic [HPS_LVL_W-1:0] pct;
	} hps_step_t;

	function automatic logic [HPS_IDX_W-1:0] hps_pat_off(input logic [HPS_PAT_W-1:0] pid);
		logic [HPS_IDX_W-1:0] off;
		case (pid)
			3'd2:    off = 6'd1;
			3'd3:    off = 6'd4;
			3'd4:    off = 6'd9;
			3'd5:    off = 6'd20;
			3'd6:    off = 6'd37;
			default: off = 6'd0;
		endcase
		return off;
	endfunction

	function automatic logic [HPS_POS_W-1:0] hps_pat_len(input logic [HPS_PAT_W-1:0] pid);
		logic [HPS_POS_W-1:0] len;
		case (pid)
			3'd1:    len = 5'd1;
			3'd2:    len = 5'd3;
			3'd3:    len = 5'd5;
			3'd4:    len = 5'd11;
			3'd5:    len = 5'd17;
			3'd6:    len = 5'd13;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic hps_step_t hps_rom(input logic [HPS_IDX_W-1:0] idx);
		hps_step_t s;
		case (idx)
			// Single and double.
			6'd0, 6'd1, 6'd3:                s = {10'd100, 7'd100};
			6'd2:                            s = {10'd100, 7'd0};
			// Triple.
			6'd4, 6'd6, 6'd8:                s = {10'd80, 7'd100};
			6'd5, 6'd7:                      s = {10'd80, 7'd0};
			// Heartbeat.
			6'd9, 6'd13, 6'd17:              s = {10'd80, 7'd100};
			6'd10, 6'd14, 6'd18:             s = {10'd60, 7'd0};
			6'd11, 6'd15, 6'd19:             s = {10'd100, 7'd80};
			6'd12, 6'd16:                    s = {10'd760, 7'd0};
			// Breathing.
			6'd20:                           s = {10'd500, 7'd20};
			6'd21:                           s = {10'd500, 7'd35};
			6'd22:                           s = {10'd500, 7'd50};
			6'd23:                           s = {10'd500, 7'd65};
			6'd24:                           s = {10'd500, 7'd80};
			6'd25:                           s = {10'd500, 7'd90};
			6'd26:                           s = {10'd500, 7'd95};
			6'd27:                           s = {10'd500, 7'd100};
			6'd28:                           s = {10'd600, 7'd90};
			6'd29:                           s = {10'd600, 7'd75};
			6'd30:                           s = {10'd600, 7'd60};
			6'd31:                           s = {10'd600, 7'd45};
			6'd32:                           s = {10'd600, 7'd30};
			6'd33:                           s = {10'd600, 7'd20};
			6'd34:                           s = {10'd600, 7'd10};
			6'd35:                           s = {10'd600, 7'd5};
			6'd36:                           s = {10'd400, 7'd0};
			// Alert.
			6'd37, 6'd39, 6'd41,
			6'd44, 6'd46, 6'd48:             s = {10'd50, 7'd100};
			6'd38, 6'd40, 6'd42,
			6'd45, 6'd47, 6'd49:             s = {10'd50, 7'd0};
			6'd43:                           s = {10'd150, 7'd0};
			default:                         s = {10'd0, 7'd0};
		endcase
		return s;
	endfunction

endpackage

FILE: design/hps_core.sv
// ----------------------------------------------------------------------------
// Haptic pattern sequencer core
// Sequencer state and its single-pass update for one command beat.
// ----------------------------------------------------------------------------
module hps_core import hps_pkg::*; #(
	parameter int TIME_BITS = HPS_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  hps_cmd_t             cmd,
	input  logic [TIME_BITS-1:0] now,
	output hps_status_t          status
);

	logic [HPS_PAT_W-1:0]  pattern_id_q, pattern_id_d;
	logic [HPS_POS_W-1:0]  step_pos_q, step_pos_d;
	logic [HPS_LVL_W-1:0]  base_q, base_d;
	logic [HPS_PROD_W-1:0] prod_q, prod_d;
	logic [TIME_BITS-1:0]  step_start_q, step_start_d;
	logic                  started_q, started_d;
	logic                  active_q, active_d;
	logic                  loop_q, loop_d;
	logic                  enable_q, enable_d;

	logic [HPS_LVL_W-1:0]  lvl_c;
	logic [HPS_POS_W-1:0]  len_cur;
	logic [HPS_POS_W-1:0]  cur_pos;
	logic [HPS_POS_W-1:0]  pos_inc;
	logic [HPS_POS_W-1:0]  apply_pos;
	logic [HPS_IDX_W-1:0]  off_cur;
	hps_step_t             cur_step;
	hps_step_t             apply_step;
	logic [TIME_BITS-1:0]  start_eff;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  step_done;
	logic                  at_end;
	logic [HPS_PROD_W-1:0] scaled;
	logic                  stop_req;

	always_comb begin
		lvl_c = (cmd.level > HPS_IN_LVL_W'(HPS_MAX_LEVEL)) ? HPS_LVL_W'(HPS_MAX_LEVEL)
			: cmd.level[HPS_LVL_W-1:0];

		len_cur  = hps_pat_len(pattern_id_q);
		off_cur  = hps_pat_off(pattern_id_q);
		cur_pos  = (step_pos_q >= len_cur) ? '0 : step_pos_q;
		cur_step = hps_rom(off_cur + HPS_IDX_W'(cur_pos));

		// Before the first tick the step starts now, so nothing has elapsed yet.
		start_eff = started_q ? step_start_q : now;
		elapsed   = now - start_eff;
		step_done = elapsed >= TIME_BITS'(cur_step.dur);

		pos_inc    = step_pos_q + 1'b1;
		at_end     = pos_inc >= len_cur;
		apply_pos  = step_done ? (at_end ? '0 : pos_inc) : cur_pos;
		apply_step = hps_rom(off_cur + HPS_IDX_W'(apply_pos));
		scaled     = HPS_PROD_W'(apply_step.pct) * HPS_PROD_W'(base_q);
	end

	always_comb begin
		pattern_id_d = pattern_id_q;
		step_pos_d   = step_pos_q;
		base_d       = base_q;
		prod_d       = prod_q;
		step_start_d = step_start_q;
		started_d    = started_q;
		active_d     = active_q;
		loop_d       = loop_q;
		enable_d     = enable_q;
		stop_req     = 1'b0;

		if (go) begin
			case (cmd.op)
				OP_PLAY: begin
					if (cmd.sel == PAT_NONE || cmd.sel == PAT_INVALID) begin
						stop_req = 1'b1;
					end else begin
						pattern_id_d = cmd.sel;
						step_pos_d   = '0;
						base_d       = lvl_c;
						started_d    = 1'b0;
						active_d     = 1'b1;
						loop_d       = (cmd.sel == PAT_BREATHING);
						enable_d     = 1'b1;
					end
				end
				OP_LEVEL: begin
					if (lvl_c == '0) begin
						stop_req = 1'b1;
					end else begin
						pattern_id_d = PAT_NONE;
						active_d     = 1'b1;
						base_d       = lvl_c;
						prod_d       = HPS_PROD_W'(lvl_c) * HPS_PROD_W'(HPS_MAX_LEVEL);
						enable_d     = 1'b1;
					end
				end
				OP_STOP: begin
					stop_req = 1'b1;
				end
				OP_TICK: begin
					if (active_q && pattern_id_q != PAT_NONE) begin
						if (!started_q) begin
							started_d    = 1'b1;
							step_start_d = now;
							prod_d       = scaled;
						end
						if (step_done) begin
							step_start_d = now;
							if (at_end && !loop_q) begin
								step_pos_d = pos_inc;
								stop_req   = 1'b1;
							end else begin
								step_pos_d = apply_pos;
								prod_d     = scaled;
							end
						end
					end
				end
				default: begin
					stop_req = 1'b0;
				end
			endcase

			if (stop_req) begin
				active_d     = 1'b0;
				pattern_id_d = PAT_NONE;
				prod_d       = '0;
				enable_d     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_id_q <= PAT_NONE;
			step_pos_q   <= '0;
			base_q       <= '0;
			prod_q       <= '0;
			step_start_q <= '0;
			started_q    <= 1'b0;
			active_q     <= 1'b0;
			loop_q       <= 1'b0;
			enable_q     <= 1'b0;
		end else begin
			pattern_id_q <= pattern_id_d;
			step_pos_q   <= step_pos_d;
			base_q       <= base_d;
			prod_q       <= prod_d;
			step_start_q <= step_start_d;
			started_q    <= started_d;
			active_q     <= active_d;
			loop_q       <= loop_d;
			enable_q     <= enable_d;
		end
	end

	assign status.prod      = prod_q;
	assign status.driver_on = enable_q;
	assign status.running   = active_q;

	// The driver is awake exactly while something is playing.
	a_enable_tracks_active: assert property (@(posedge clk) disable iff (!arst_n)
		enable_q == active_q)
		else $error("driver enable and active flag disagree");

	a_idle_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> prod_q == '0)
		else $error("level held while inactive");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_pos_q <= HPS_POS_W'(HPS_MAX_LEN))
		else $error("step position beyond longest pattern");

endmodule

FILE: design/hps_out.sv
// ----------------------------------------------------------------------------
// Haptic pattern sequencer output stage
// Scales the stored level product down to a duty percent and holds the result.
// ----------------------------------------------------------------------------
module hps_out import hps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  hps_status_t          status,
	input  logic                 res_stall,
	output logic                 free,
	output logic                 res_valid,
	output logic [HPS_LVL_W-1:0] duty,
	output logic                 driver_on,
	output logic                 running
);

	localparam int QuotW = HPS_PROD_W + HPS_DIV_MUL_W;

	logic [QuotW-1:0]     recip_prod;
	logic [HPS_LVL_W-1:0] duty_c;
	logic                 valid_q;
	logic [HPS_LVL_W-1:0] duty_q;
	logic                 driver_q;
	logic                 running_q;

	// The product is at most 10000, so the quotient fits in seven bits.
	assign recip_prod = QuotW'(status.prod) * QuotW'(HPS_DIV100_MUL);
	assign duty_c     = recip_prod[HPS_DIV100_SHIFT +: HPS_LVL_W];

	assign free = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			duty_q    <= duty_c;
			driver_q  <= status.driver_on;
			running_q <= status.running;
		end
	end

	assign res_valid = valid_q;
	assign duty      = duty_q;
	assign driver_on = driver_q;
	assign running   = running_q;

endmodule

FILE: design/haptic_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// Haptic pattern sequencer
// Plays vibration patterns from a fixed step ROM and reports the driven duty.
// ----------------------------------------------------------------------------
// Usage: each command beat (tick, play, constant level, stop) on the cmd
// channel produces exactly one result beat on the res channel carrying the
// duty percent, the driver enable and the running flag after that command.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// Pipeline: a command is registered on acceptance, then updates the sequencer
// state registers, then its result is registered in the output stage.
// Throughput: one command per cycle while the receiver does not stall; the
// state update is a single pass with two step ROM lookups, one 32-bit time
// compare and one 7x7 multiply; the division by 100 sits in the output stage.
// Reset clears the pipeline and the state: no pattern, driver asleep, zero
// level product; the output data registers are not reset. When the receiver
// stalls, the held result stays put, the two internal stages fill, and
// cmd_stall rises once both are occupied.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer import hps_pkg::*; #(
	parameter int TIME_BITS = HPS_TIME_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [1:0]              opcode,
	input  logic [HPS_PAT_W-1:0]    pattern_select,
	input  logic [HPS_IN_LVL_W-1:0] intensity,
	input  logic [31:0]             time_ms,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [HPS_LVL_W-1:0]    duty,
	output logic                    driver_on,
	output logic                    running
);

	logic                 s1_valid_q;
	hps_cmd_t             cmd_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 s2_valid_q;
	logic                 s1_free;
	logic                 s2_free;
	logic                 s1_adv;
	logic                 out_free;
	logic                 out_load;
	hps_status_t          status;

	// The second stage holds no data: the state registers carry its result.
	assign s2_free  = !s2_valid_q || out_free;
	assign s1_adv   = s1_valid_q && s2_free;
	assign s1_free  = !s1_valid_q || s2_free;
	assign out_load = s2_valid_q && out_free;

	assign cmd_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= cmd_valid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && cmd_valid) begin
			cmd_s1.op    <= hps_op_t'(opcode);
			cmd_s1.sel   <= pattern_select;
			cmd_s1.level <= intensity;
			time_s1      <= time_ms[TIME_BITS-1:0];
		end
	end

	hps_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_adv),
		.cmd    (cmd_s1),
		.now    (time_s1),
		.status (status)
	);

	hps_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.status    (status),
		.res_stall (res_stall),
		.free      (out_free),
		.res_valid (res_valid),
		.duty      (duty),
		.driver_on (driver_on),
		.running   (running)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> s1_valid_q && s2_valid_q && res_valid)
		else $error("command stalled with room in the pipeline");

	a_duty_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> duty <= HPS_LVL_W'(HPS_MAX_LEVEL))
		else $error("duty above full scale");

	a_idle_result_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !running |-> duty == '0 && !driver_on)
		else $error("idle result drives the motor");

endmodule
